@@ sv/lavm_pkg.sv @@
// shared types, constants and helper functions for the look-at view matrix block
`timescale 1ns / 1ps

package lavm_pkg;

  localparam int VEC_W     = 64;
  localparam int NBYTE     = VEC_W / 8;
  localparam int MAG_W     = 31;
  localparam int TOP_POS   = MAG_W - 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int LEN_W     = 32;
  localparam int AX_W      = 32;
  localparam int EYE_W     = 49;
  localparam int EYE_SPLIT = 24;
  localparam int PRD_W     = AX_W + EYE_W - EYE_SPLIT;
  localparam int DOT_W     = 84;
  localparam int COL_W     = 32;
  localparam int IN_W      = 32;
  localparam int PRE_LAT   = 4;

  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [AX_W-1:0]  ax_t;
  typedef logic signed [EYE_W-1:0] eye_t;
  typedef logic signed [DOT_W:0]   wide_t;
  typedef logic [COL_W-1:0]        col_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  nz;
  } pre_t;

  // pipeline depth of one normalize unit
  function automatic int norm_lat(input int frac);
    return frac + 41;
  endfunction

  // position of the highest set bit in a byte
  function automatic logic [2:0] hb8(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        pos = 3'(k);
      end
    end
    return pos;
  endfunction

  // clamp to the signed range of sb bits, keep the low column bits
  function automatic col_t sat_out(input wide_t x, input int unsigned sb);
    wide_t hi;
    wide_t lo;
    wide_t r;
    hi = (wide_t'(1) <<< (sb - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r[COL_W-1:0];
  endfunction

endpackage

@@ sv/lavm_prescale.sv @@
// magnitude prescale of a 3-vector into [2^30, 2^31), four register stages
`timescale 1ns / 1ps

module lavm_prescale (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  lavm_pkg::vec_t [2:0]     vec_i,
  output logic                     valid_o,
  output lavm_pkg::pre_t           pre_o
);

  logic [2:0] v_q;
  logic       out_v_q;

  logic [2:0][lavm_pkg::VEC_W-1:0] a_mag_d, a_mag_q, b_mag_q, c_mag_q;
  logic [2:0]                      a_neg_q, b_neg_q, c_neg_q;

  logic [lavm_pkg::VEC_W-1:0]        b_or;
  logic [lavm_pkg::NBYTE-1:0]        b_nz_d, b_nz_q;
  logic [lavm_pkg::NBYTE-1:0][2:0]   b_pos_d, b_pos_q;

  logic [5:0] c_top;
  logic       c_right_d, c_right_q;
  logic [5:0] c_amt_d, c_amt_q;
  logic       c_nz_d, c_nz_q;

  logic [2:0][lavm_pkg::VEC_W-1:0] d_sh;
  lavm_pkg::pre_t                  pre_d, pre_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag_d[i] = vec_i[i][lavm_pkg::VEC_W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
  end

  always_comb begin
    b_or = a_mag_q[0] | a_mag_q[1] | a_mag_q[2];
    for (int j = 0; j < lavm_pkg::NBYTE; j++) begin
      b_nz_d[j]  = |b_or[8*j +: 8];
      b_pos_d[j] = lavm_pkg::hb8(b_or[8*j +: 8]);
    end
  end

  always_comb begin
    c_top = 6'd0;
    for (int j = 0; j < lavm_pkg::NBYTE; j++) begin
      if (b_nz_q[j]) begin
        c_top = {3'(j), b_pos_q[j]};
      end
    end
    c_nz_d    = |b_nz_q;
    c_right_d = c_top > 6'(lavm_pkg::TOP_POS);
    c_amt_d   = c_right_d ? (c_top - 6'(lavm_pkg::TOP_POS)) : (6'(lavm_pkg::TOP_POS) - c_top);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_sh[i]         = c_right_q ? (c_mag_q[i] >> c_amt_q) : (c_mag_q[i] << c_amt_q);
      pre_d.mag[i]    = d_sh[i][lavm_pkg::MAG_W-1:0];
    end
    pre_d.neg = c_neg_q;
    pre_d.nz  = c_nz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= {v_q[1:0], valid_i};
      out_v_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    a_mag_q   <= a_mag_d;
    a_neg_q   <= {vec_i[2][lavm_pkg::VEC_W-1], vec_i[1][lavm_pkg::VEC_W-1],
                  vec_i[0][lavm_pkg::VEC_W-1]};
    b_mag_q   <= a_mag_q;
    b_neg_q   <= a_neg_q;
    b_nz_q    <= b_nz_d;
    b_pos_q   <= b_pos_d;
    c_mag_q   <= b_mag_q;
    c_neg_q   <= b_neg_q;
    c_right_q <= c_right_d;
    c_amt_q   <= c_amt_d;
    c_nz_q    <= c_nz_d;
    pre_q     <= pre_d;
  end

  assign valid_o = out_v_q;
  assign pre_o   = pre_q;

endmodule

@@ sv/lavm_norm.sv @@
// pipelined 3-vector normalize: prescale, sum of squares, square root, division
`timescale 1ns / 1ps

module lavm_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  lavm_pkg::vec_t [2:0]  vec_i,
  output logic                  valid_o,
  output lavm_pkg::ax_t [2:0]   unit_o,
  output logic                  ok_o
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int STEPS = lavm_pkg::LEN_W;

  logic           p_v;
  lavm_pkg::pre_t p_pre;

  logic                                m_v_q;
  lavm_pkg::pre_t                      m_pre_q;
  logic [2:0][lavm_pkg::SQ_W-1:0]      m_sq_q;

  logic [STEPS:0]             sq_v_q;
  logic [2*STEPS-1:0]         sq_n_q   [STEPS+1];
  logic [2*STEPS-1:0]         sq_r_q   [STEPS+1];
  lavm_pkg::pre_t             sq_pre_q [STEPS+1];

  logic [QW:0]                          dv_v_q;
  logic [2:0][lavm_pkg::LEN_W-1:0]      dv_rem_q [QW+1];
  logic [2:0][QW-1:0]                   dv_quo_q [QW+1];
  logic [lavm_pkg::LEN_W-1:0]           dv_len_q [QW+1];
  logic [2:0]                           dv_neg_q [QW+1];
  logic                                 dv_nz_q  [QW+1];

  logic                      o_v_q;
  lavm_pkg::ax_t [2:0]       o_unit_d, o_unit_q;
  logic                      o_ok_q;

  lavm_prescale u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .vec_i   (vec_i),
    .valid_o (p_v),
    .pre_o   (p_pre)
  );

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m_sq_q[i] <= lavm_pkg::SQ_W'(p_pre.mag[i]) * lavm_pkg::SQ_W'(p_pre.mag[i]);
    end
    m_pre_q     <= p_pre;
    sq_n_q[0]   <= (2*STEPS)'(m_sq_q[0]) + (2*STEPS)'(m_sq_q[1]) + (2*STEPS)'(m_sq_q[2]);
    sq_r_q[0]   <= '0;
    sq_pre_q[0] <= m_pre_q;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [2*STEPS-1:0] Bit = (2*STEPS)'(1) << (2 * (STEPS - 1 - k));
    logic [2*STEPS-1:0] trial;
    logic               ge;
    assign trial = sq_r_q[k] + Bit;
    assign ge    = sq_n_q[k] >= trial;
    always_ff @(posedge clk_i) begin
      sq_n_q[k+1]   <= ge ? (sq_n_q[k] - trial) : sq_n_q[k];
      sq_r_q[k+1]   <= ge ? ((sq_r_q[k] >> 1) + Bit) : (sq_r_q[k] >> 1);
      sq_pre_q[k+1] <= sq_pre_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_q[0][i] <= lavm_pkg::LEN_W'(sq_pre_q[STEPS].mag[i]);
    end
    dv_quo_q[0] <= '0;
    dv_len_q[0] <= sq_r_q[STEPS][lavm_pkg::LEN_W-1:0];
    dv_neg_q[0] <= sq_pre_q[STEPS].neg;
    dv_nz_q[0]  <= sq_pre_q[STEPS].nz;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam logic [QW-1:0] QBit = QW'(1) << (QW - 1 - k);
    logic [2:0][lavm_pkg::LEN_W:0] sh;
    logic [2:0]                    ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = (k == 0) ? {1'b0, dv_rem_q[k][i]} : {dv_rem_q[k][i], 1'b0};
        ge[i] = sh[i] >= {1'b0, dv_len_q[k]};
      end
    end
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[k+1][i] <= ge[i] ? lavm_pkg::LEN_W'(sh[i] - {1'b0, dv_len_q[k]})
                                  : sh[i][lavm_pkg::LEN_W-1:0];
        dv_quo_q[k+1][i] <= ge[i] ? (dv_quo_q[k][i] | QBit) : dv_quo_q[k][i];
      end
      dv_len_q[k+1] <= dv_len_q[k];
      dv_neg_q[k+1] <= dv_neg_q[k];
      dv_nz_q[k+1]  <= dv_nz_q[k];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_nz_q[QW]) begin
        o_unit_d[i] = '0;
      end else if (dv_neg_q[QW][i]) begin
        o_unit_d[i] = -lavm_pkg::AX_W'(dv_quo_q[QW][i]);
      end else begin
        o_unit_d[i] = lavm_pkg::AX_W'(dv_quo_q[QW][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    o_unit_q <= o_unit_d;
    o_ok_q   <= dv_nz_q[QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q  <= 1'b0;
      sq_v_q <= '0;
      dv_v_q <= '0;
      o_v_q  <= 1'b0;
    end else begin
      m_v_q  <= p_v;
      sq_v_q <= {sq_v_q[STEPS-1:0], m_v_q};
      dv_v_q <= {dv_v_q[QW-1:0], sq_v_q[STEPS]};
      o_v_q  <= dv_v_q[QW];
    end
  end

  assign valid_o = o_v_q;
  assign unit_o  = o_unit_q;
  assign ok_o    = o_ok_q;

endmodule

@@ sv/look_at_view_matrix.sv @@
// top level of the look-at view matrix block
// Usage: drive eye, target and up hint on the input ports and raise start_i;
// the item is taken at a rising edge where start_i is high and busy_o low.
// busy_o then stays high until its gap counter runs down, and no item is taken
// meanwhile; a new item is taken while earlier ones are still in the pipeline.
// Each item gives four result beats, rows 0 to 3 on consecutive cycles,
// each marked by res_valid_o for one cycle; last_row_o flags row 3.
// The path from the accepting edge to the first row beat runs through three
// normalize units in series, each with a 32-step square root and a
// FRAC_BITS + 1 step divider. The busy_o gap is set by the single result
// port that carries four rows.
// Reset clears every valid bit and busy_o; items in flight are dropped.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
`timescale 1ns / 1ps

module look_at_view_matrix #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  input  logic [31:0] eye_z_i,
  input  logic [31:0] target_x_i,
  input  logic [31:0] target_y_i,
  input  logic [31:0] target_z_i,
  input  logic [31:0] up_hint_x_i,
  input  logic [31:0] up_hint_y_i,
  input  logic [31:0] up_hint_z_i,
  output logic        res_valid_o,
  output logic [1:0]  row_index_o,
  output logic [31:0] col0_o,
  output logic [31:0] col1_o,
  output logic [31:0] col2_o,
  output logic [31:0] col3_o,
  output logic        last_row_o,
  output logic        degenerate_o
);

  localparam int SH       = (COORD_BITS < lavm_pkg::IN_W) ? (lavm_pkg::IN_W - COORD_BITS) : 0;
  localparam int SAT_BITS = (COORD_BITS < lavm_pkg::COL_W) ? COORD_BITS : lavm_pkg::COL_W;
  localparam int NL       = lavm_pkg::norm_lat(FRAC_BITS);
  localparam int UPL      = NL - lavm_pkg::PRE_LAT;
  localparam lavm_pkg::col_t ONE_COL =
    lavm_pkg::sat_out(lavm_pkg::wide_t'(1) <<< FRAC_BITS, SAT_BITS);

  typedef struct packed {
    lavm_pkg::ax_t  [2:0] fwd;
    lavm_pkg::eye_t [2:0] eye;
    logic                 ok;
  } side2_t;

  typedef struct packed {
    lavm_pkg::ax_t  [2:0] fwd;
    lavm_pkg::ax_t  [2:0] rgt;
    lavm_pkg::eye_t [2:0] eye;
    logic                 ok;
  } side3_t;

  typedef struct packed {
    lavm_pkg::ax_t [2:0] ups;
    logic                nz;
  } upd_t;

  // input beat
  logic [1:0] gap_q;
  logic       accept;
  logic [8:0][lavm_pkg::IN_W-1:0] raw;
  lavm_pkg::eye_t [8:0]            crd;

  logic                  s0_v_q;
  lavm_pkg::eye_t [2:0]  s0_eye_q;
  lavm_pkg::vec_t [2:0]  s0_diff_q;
  lavm_pkg::vec_t [2:0]  s0_up_q;

  // first normalize and up hint prescale
  logic                  n1_v, n1_ok;
  lavm_pkg::ax_t [2:0]   n1_u;
  logic                  pu_v;
  lavm_pkg::pre_t        pu_pre;
  upd_t                  up_d;
  upd_t                  up_dl_q  [UPL];
  lavm_pkg::eye_t [2:0]  eye_dl_q [NL];

  // first cross product
  logic                        x1_v_q, x2_v_q;
  logic signed [lavm_pkg::VEC_W-1:0] x1_p_q [6];
  side2_t                      x1_sd_q, x2_sd_q;
  lavm_pkg::vec_t [2:0]        x2_cr_q;

  logic                  n2_v, n2_ok;
  lavm_pkg::ax_t [2:0]   n2_u;
  side2_t                s2_dl_q [NL];

  // second cross product
  logic                        y1_v_q, y2_v_q;
  logic signed [lavm_pkg::VEC_W-1:0] y1_p_q [6];
  side3_t                      y1_sd_q, y2_sd_q;
  lavm_pkg::vec_t [2:0]        y2_cr_q;

  logic                  n3_v, n3_ok;
  lavm_pkg::ax_t [2:0]   n3_u;
  side3_t                s3_dl_q [NL];

  // translation
  logic                          t1_v_q, t2_v_q, t3_v_q, t4_v_q;
  lavm_pkg::ax_t [2:0][2:0]      t_ax_d;
  lavm_pkg::ax_t [2:0][2:0]      t1_ax_q, t2_ax_q, t3_ax_q;
  logic                          t1_ok_q, t2_ok_q, t3_ok_q, t4_ok_q;
  logic signed [lavm_pkg::PRD_W-1:0] t1_lo_q [3][3];
  logic signed [lavm_pkg::PRD_W-1:0] t1_hi_q [3][3];
  logic signed [lavm_pkg::DOT_W-1:0] t2_prod_q [3][3];
  logic signed [lavm_pkg::DOT_W-1:0] t3_dot_q [3];
  lavm_pkg::col_t [2:0][3:0]     t4_col_d, t4_col_q;

  // row sequencer
  logic                      act_q;
  logic [1:0]                cnt_q;
  lavm_pkg::col_t [3:0][3:0] hd_col_q;
  logic                      hd_deg_q;

  logic                      res_valid_q;
  logic [1:0]                row_q;
  lavm_pkg::col_t [3:0]      col_q;
  logic                      last_q;
  logic                      deg_q;

  assign accept = start_i && !busy_o;
  assign busy_o = gap_q != 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 2'd0;
    end else if (accept) begin
      gap_q <= 2'd3;
    end else if (gap_q != 2'd0) begin
      gap_q <= gap_q - 2'd1;
    end
  end

  assign raw = {up_hint_z_i, up_hint_y_i, up_hint_x_i, target_z_i, target_y_i, target_x_i,
                eye_z_i, eye_y_i, eye_x_i};

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (COORD_BITS > lavm_pkg::IN_W) begin
        crd[i] = lavm_pkg::eye_t'({1'b0, raw[i]});
      end else begin
        crd[i] = lavm_pkg::eye_t'($signed(raw[i] << SH) >>> SH);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s0_eye_q[i]  <= crd[i];
      s0_diff_q[i] <= lavm_pkg::VEC_W'($signed(crd[i]) - $signed(crd[3+i]));
      s0_up_q[i]   <= lavm_pkg::VEC_W'($signed(crd[6+i]));
    end
  end

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_v_q),
    .vec_i   (s0_diff_q),
    .valid_o (n1_v),
    .unit_o  (n1_u),
    .ok_o    (n1_ok)
  );

  lavm_prescale u_pre_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_v_q),
    .vec_i   (s0_up_q),
    .valid_o (pu_v),
    .pre_o   (pu_pre)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_d.ups[i] = pu_pre.neg[i] ? -lavm_pkg::AX_W'(pu_pre.mag[i])
                                  : lavm_pkg::AX_W'(pu_pre.mag[i]);
    end
    up_d.nz = pu_pre.nz;
  end

  always_ff @(posedge clk_i) begin
    up_dl_q[0]  <= up_d;
    eye_dl_q[0] <= s0_eye_q;
    for (int k = 1; k < UPL; k++) begin
      up_dl_q[k] <= up_dl_q[k-1];
    end
    for (int k = 1; k < NL; k++) begin
      eye_dl_q[k] <= eye_dl_q[k-1];
    end
  end

  // up x fwd
  always_ff @(posedge clk_i) begin
    x1_p_q[0] <= $signed(up_dl_q[UPL-1].ups[1]) * $signed(n1_u[2]);
    x1_p_q[1] <= $signed(up_dl_q[UPL-1].ups[2]) * $signed(n1_u[1]);
    x1_p_q[2] <= $signed(up_dl_q[UPL-1].ups[2]) * $signed(n1_u[0]);
    x1_p_q[3] <= $signed(up_dl_q[UPL-1].ups[0]) * $signed(n1_u[2]);
    x1_p_q[4] <= $signed(up_dl_q[UPL-1].ups[0]) * $signed(n1_u[1]);
    x1_p_q[5] <= $signed(up_dl_q[UPL-1].ups[1]) * $signed(n1_u[0]);
    x1_sd_q.fwd <= n1_u;
    x1_sd_q.eye <= eye_dl_q[NL-1];
    x1_sd_q.ok  <= n1_ok && up_dl_q[UPL-1].nz;
    x2_cr_q[0]  <= x1_p_q[0] - x1_p_q[1];
    x2_cr_q[1]  <= x1_p_q[2] - x1_p_q[3];
    x2_cr_q[2]  <= x1_p_q[4] - x1_p_q[5];
    x2_sd_q     <= x1_sd_q;
  end

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_rgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x2_v_q),
    .vec_i   (x2_cr_q),
    .valid_o (n2_v),
    .unit_o  (n2_u),
    .ok_o    (n2_ok)
  );

  always_ff @(posedge clk_i) begin
    s2_dl_q[0] <= x2_sd_q;
    for (int k = 1; k < NL; k++) begin
      s2_dl_q[k] <= s2_dl_q[k-1];
    end
  end

  // fwd x right
  always_ff @(posedge clk_i) begin
    y1_p_q[0] <= $signed(s2_dl_q[NL-1].fwd[1]) * $signed(n2_u[2]);
    y1_p_q[1] <= $signed(s2_dl_q[NL-1].fwd[2]) * $signed(n2_u[1]);
    y1_p_q[2] <= $signed(s2_dl_q[NL-1].fwd[2]) * $signed(n2_u[0]);
    y1_p_q[3] <= $signed(s2_dl_q[NL-1].fwd[0]) * $signed(n2_u[2]);
    y1_p_q[4] <= $signed(s2_dl_q[NL-1].fwd[0]) * $signed(n2_u[1]);
    y1_p_q[5] <= $signed(s2_dl_q[NL-1].fwd[1]) * $signed(n2_u[0]);
    y1_sd_q.fwd <= s2_dl_q[NL-1].fwd;
    y1_sd_q.rgt <= n2_u;
    y1_sd_q.eye <= s2_dl_q[NL-1].eye;
    y1_sd_q.ok  <= s2_dl_q[NL-1].ok && n2_ok;
    y2_cr_q[0]  <= y1_p_q[0] - y1_p_q[1];
    y2_cr_q[1]  <= y1_p_q[2] - y1_p_q[3];
    y2_cr_q[2]  <= y1_p_q[4] - y1_p_q[5];
    y2_sd_q     <= y1_sd_q;
  end

  lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (y2_v_q),
    .vec_i   (y2_cr_q),
    .valid_o (n3_v),
    .unit_o  (n3_u),
    .ok_o    (n3_ok)
  );

  always_ff @(posedge clk_i) begin
    s3_dl_q[0] <= y2_sd_q;
    for (int k = 1; k < NL; k++) begin
      s3_dl_q[k] <= s3_dl_q[k-1];
    end
  end

  // rows: right, up, forward
  assign t_ax_d[0] = s3_dl_q[NL-1].rgt;
  assign t_ax_d[1] = n3_u;
  assign t_ax_d[2] = s3_dl_q[NL-1].fwd;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        t1_lo_q[r][i] <= $signed(t_ax_d[r][i]) *
                         $signed({1'b0, s3_dl_q[NL-1].eye[i][lavm_pkg::EYE_SPLIT-1:0]});
        t1_hi_q[r][i] <= $signed(t_ax_d[r][i]) *
                         $signed(s3_dl_q[NL-1].eye[i][lavm_pkg::EYE_W-1:lavm_pkg::EYE_SPLIT]);
      end
    end
    t1_ax_q <= t_ax_d;
    t1_ok_q <= s3_dl_q[NL-1].ok && n3_ok;
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        t2_prod_q[r][i] <= (lavm_pkg::DOT_W'(t1_hi_q[r][i]) <<< lavm_pkg::EYE_SPLIT) +
                           lavm_pkg::DOT_W'(t1_lo_q[r][i]);
      end
      t3_dot_q[r] <= t2_prod_q[r][0] + t2_prod_q[r][1] + t2_prod_q[r][2];
    end
    t2_ax_q <= t1_ax_q;
    t2_ok_q <= t1_ok_q;
    t3_ax_q <= t2_ax_q;
    t3_ok_q <= t2_ok_q;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        t4_col_d[r][i] = t3_ok_q ?
          lavm_pkg::sat_out(lavm_pkg::wide_t'(t3_ax_q[r][i]), SAT_BITS) : '0;
      end
      t4_col_d[r][3] = t3_ok_q ?
        lavm_pkg::sat_out(-lavm_pkg::wide_t'(t3_dot_q[r] >>> FRAC_BITS), SAT_BITS) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    t4_col_q <= t4_col_d;
    t4_ok_q  <= t3_ok_q;
  end

  // row sequencer, one row beat per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= 2'd0;
    end else if (t4_v_q) begin
      act_q <= 1'b1;
      cnt_q <= 2'd0;
    end else if (act_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == lavm_pkg::ROW_LAST) begin
        act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (t4_v_q) begin
      for (int r = 0; r < 3; r++) begin
        hd_col_q[r] <= t4_col_q[r];
      end
      hd_col_q[3] <= {ONE_COL, lavm_pkg::col_t'(0), lavm_pkg::col_t'(0), lavm_pkg::col_t'(0)};
      hd_deg_q    <= !t4_ok_q;
    end
    row_q  <= cnt_q;
    col_q  <= hd_col_q[cnt_q];
    last_q <= cnt_q == lavm_pkg::ROW_LAST;
    deg_q  <= hd_deg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q      <= 1'b0;
      x1_v_q      <= 1'b0;
      x2_v_q      <= 1'b0;
      y1_v_q      <= 1'b0;
      y2_v_q      <= 1'b0;
      t1_v_q      <= 1'b0;
      t2_v_q      <= 1'b0;
      t3_v_q      <= 1'b0;
      t4_v_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s0_v_q      <= accept;
      x1_v_q      <= n1_v;
      x2_v_q      <= x1_v_q;
      y1_v_q      <= n2_v;
      y2_v_q      <= y1_v_q;
      t1_v_q      <= n3_v;
      t2_v_q      <= t1_v_q;
      t3_v_q      <= t2_v_q;
      t4_v_q      <= t3_v_q;
      res_valid_q <= act_q;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign row_index_o  = row_q;
  assign col0_o       = col_q[0];
  assign col1_o       = col_q[1];
  assign col2_o       = col_q[2];
  assign col3_o       = col_q[3];
  assign last_row_o   = last_q;
  assign degenerate_o = deg_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after an accepted item");

  a_up_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pu_v |-> ##UPL n1_v)
    else $error("up hint path out of step with forward normalize");

  a_rows_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_row_o |=> res_valid_o && row_index_o == $past(row_index_o) + 2'd1)
    else $error("row beats not consecutive");

  a_deg_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_row_o |=> degenerate_o == $past(degenerate_o))
    else $error("degenerate flag changed within one matrix");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_row_o |-> row_index_o == lavm_pkg::ROW_LAST && col3_o == ONE_COL)
    else $error("last row beat malformed");

endmodule

@@ verif/look_at_view_matrix_tb.sv @@
// self-checking testbench for the look-at view matrix block
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

  localparam int FRAC = 16;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam int DRAIN_CYCLES = 3 * FRAC + 133 + 50;

  typedef longint vec3_t [3];
  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0, c1, c2, c3;
    logic        last, degen;
  } row_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic [31:0] up_hint_x_i = '0, up_hint_y_i = '0, up_hint_z_i = '0;
  logic res_valid_o;
  logic [1:0] row_index_o;
  logic [31:0] col0_o, col1_o, col2_o, col3_o;
  logic last_row_o, degenerate_o;

  row_beat_t pending_rows [$];
  int errors = 0;
  int idle_pct = 0;

  always #4 clk_i = ~clk_i;

  look_at_view_matrix dut (.*);

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale so the largest magnitude lands in [2^30, 2^31)
  function automatic bit fit_range(input vec3_t v, output vec3_t o, output logic [63:0] m [3]);
    logic [63:0] mx;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return 1'b0;
    end
    while (mx >= 64'h8000_0000) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < 64'h4000_0000) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) o[i] = v[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
    return 1'b1;
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t u);
    vec3_t s;
    logic [63:0] m [3];
    logic [63:0] len;
    longint q;
    if (!fit_range(v, s, m)) begin
      u = '{0, 0, 0};
      return 1'b0;
    end
    len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = longint'((m[i] << FRAC) / len);
      u[i] = v[i] < 0 ? -q : q;
    end
    return 1'b1;
  endfunction

  function automatic vec3_t cross_vec(input vec3_t a, input vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return MAXV;
    if (x < -64'sd2147483648) return MINV;
    return x[31:0];
  endfunction

  function automatic void predict_view_rows(input logic [31:0] f [9]);
    vec3_t eye, diff, uph, ups, fwd, cr, rgt, upv;
    vec3_t axis [3];
    logic [63:0] mt [3];
    longint dot;
    bit ok;
    row_beat_t b;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(f[i]));
      diff[i] = eye[i] - longint'($signed(f[3 + i]));
      uph[i] = longint'($signed(f[6 + i]));
    end
    ok = unit_vec(diff, fwd);
    ok = fit_range(uph, ups, mt) && ok;
    cr = cross_vec(ups, fwd);
    ok = unit_vec(cr, rgt) && ok;
    cr = cross_vec(fwd, rgt);
    ok = unit_vec(cr, upv) && ok;
    axis[0] = rgt;
    axis[1] = upv;
    axis[2] = fwd;
    for (int r = 0; r < 4; r++) begin
      b.row = 2'(r);
      b.last = (r == 3);
      b.degen = !ok;
      {b.c0, b.c1, b.c2, b.c3} = '0;
      if (r == 3) begin
        b.c3 = clamp32(longint'(1) << FRAC);
      end else if (ok) begin
        b.c0 = clamp32(axis[r][0]);
        b.c1 = clamp32(axis[r][1]);
        b.c2 = clamp32(axis[r][2]);
        dot = axis[r][0] * eye[0] + axis[r][1] * eye[1] + axis[r][2] * eye[2];
        b.c3 = clamp32(-(dot >>> FRAC));
      end
      pending_rows.push_back(b);
    end
  endfunction

  // call at a rising edge; returns once the item has been taken
  task automatic send_view(input logic [31:0] f [9]);
    bit taken;
    start_i <= 1'b1;
    {eye_x_i, eye_y_i, eye_z_i} <= {f[0], f[1], f[2]};
    {target_x_i, target_y_i, target_z_i} <= {f[3], f[4], f[5]};
    {up_hint_x_i, up_hint_y_i, up_hint_z_i} <= {f[6], f[7], f[8]};
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    predict_view_rows(f);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_coords(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    logic [31:0] f [9];
    f = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    send_view(f);
  endtask

  always @(negedge clk_i) begin
    row_beat_t e;
    logic [31:0] want [7];
    logic [31:0] got [7];
    string nm [7];
    if (rst_ni && res_valid_o) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row beat, row %0d", $time, row_index_o);
        errors++;
      end else begin
        e = pending_rows.pop_front();
        nm = '{"row_index", "col0", "col1", "col2", "col3", "last_row", "degenerate"};
        want = '{e.row, e.c0, e.c1, e.c2, e.c3, e.last, e.degen};
        got = '{row_index_o, col0_o, col1_o, col2_o, col3_o, last_row_o, degenerate_o};
        for (int i = 0; i < 7; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %h got %h", $time, nm[i], want[i], got[i]);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(31);
  endfunction

  task automatic test_basic_views();
    send_coords(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
    send_coords(3 * ONE, 2 * ONE, ONE, -ONE, 4 * ONE, 0, 0, ONE, 0);
    send_coords(-7 * ONE, ONE, -2 * ONE, 2 * ONE, -3 * ONE, 9 * ONE, ONE, ONE, -ONE);
    send_coords(ONE, 0, 0, 0, 0, 0, 0, 0, ONE);
  endtask

  task automatic test_degenerate();
    send_coords(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);
    send_coords(0, 0, ONE, 0, 0, 0, 0, 0, 0);
    send_coords(0, 0, ONE, 0, 0, -ONE, 0, 0, 3 * ONE);
    send_coords(0, 5 * ONE, 0, 0, 0, 0, 0, -ONE, 0);
    send_coords(MINV, MINV, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV);
  endtask

  task automatic test_extremes();
    send_coords(MAXV, MAXV, MAXV, 0, 0, 0, 0, ONE, 0);
    send_coords(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MINV);
    send_coords(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, 1);
    send_coords('1, 0, '1, 1, 0, 0, '1, '1, 0);
    send_coords(1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_coords(MAXV, MINV, 0, MINV, MAXV, 1, 32'h5555_5555, 32'haaaa_aaaa, '1);
    send_coords(MINV, 0, 0, 0, 0, 0, 0, MINV, 0);
  endtask

  task automatic test_random(input int n, input int pct);
    logic [31:0] f [9];
    int ax;
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) f[i] = rand_coord();
      case ($urandom_range(9))
        0: f[3:5] = f[0:2];
        1: f[6:8] = '{0, 0, 0};
        2: begin
          ax = $urandom_range(2);
          f[3:5] = f[0:2];
          f[3 + ax] = rand_coord();
          f[6:8] = '{0, 0, 0};
          f[6 + ax] = rand_coord();
        end
        3: for (int i = 0; i < 9; i++) f[i] = $urandom;
        default: f[6:8] = '{0, ONE, 0};
      endcase
      send_view(f);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_views();
    test_degenerate();
    test_extremes();
    test_random(70, 22);
    test_random(70, 53);
    test_random(74, 0);
    start_i <= 1'b0;
    wait (pending_rows.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("look_at_view_matrix_tb: PASS");
    end else begin
      $display("look_at_view_matrix_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("look_at_view_matrix_tb: FAIL");
    $finish;
  end

endmodule
